// File: hw/rtl/rect_to_polar_converter_macros.svh
// Assertion macros for the rect-to-polar converter.
// Included by the one module with concurrent assertions; needs nothing else.
`ifndef RECT_TO_POLAR_CONVERTER_MACROS_SVH
`define RECT_TO_POLAR_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RTP_ASSERT_IMPLY(name, clk_s, rst_s, pre, post) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error("rtp: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define RTP_ASSERT_NEXT(name, clk_s, rst_s, pre, post) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error("rtp: next-cycle check failed");

`endif

// File: hw/rtl/rtp_pkg.sv
// Shared constants and the arctangent table of the rect-to-polar converter.
// No dependencies; every other file but the macro header imports it.
package rtp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF  = 16;

  // angle accumulator: signed, 24 fraction bits
  localparam int ANG_W    = 28;
  localparam int ANG_FRAC = 24;
  localparam logic signed [ANG_W-1:0] PI_Q24     = 28'sd52707179;
  localparam logic signed [ANG_W-1:0] ROUND_BIAS = 28'sd1024;

  // result words
  localparam int OUT_W    = 16;
  localparam int OUT_FRAC = 13;
  localparam int ANG_SHIFT = ANG_FRAC - OUT_FRAC;
  localparam logic signed [OUT_W-1:0] OUT_PI  = 16'sd25736;
  localparam logic        [OUT_W-1:0] MAG_MAX = '1;

  // atan(2^-i) in Q24, rounded to nearest; exact powers of two past the table
  function automatic logic signed [ANG_W-1:0] atan_q24(input int unsigned i);
    logic signed [ANG_W-1:0] one;
    one = 1;
    unique case (i)
      0: return 28'sd13176795;
      1: return 28'sd7778716;
      2: return 28'sd4110060;
      3: return 28'sd2086331;
      4: return 28'sd1047214;
      5: return 28'sd524117;
      6: return 28'sd262123;
      7: return 28'sd131069;
      8: return 28'sd65536;
      9: return 28'sd32768;
      default: begin
        if (i <= ANG_FRAC) return one <<< (ANG_FRAC - i);
        else return '0;
      end
    endcase
  endfunction

endpackage

// File: hw/rtl/rtp_point_if.sv
// Input channel of the converter: one Cartesian point per word.
// Depends on rtp_pkg for the default coordinate width.
interface rtp_point_if import rtp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, x_coord, y_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

// File: hw/rtl/rtp_polar_if.sv
// Output channel of the converter: magnitude and angle per word.
// Depends on rtp_pkg for the result width.
interface rtp_polar_if import rtp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [OUT_W-1:0] magnitude;
  logic signed [OUT_W-1:0] angle_rad;

  modport source (output valid, magnitude, angle_rad, input ready);
  modport sink   (input valid, magnitude, angle_rad, output ready);
endinterface

// File: hw/rtl/rtp_step.sv
// One pipeline stage: a CORDIC vectoring rotation and one square-root digit.
// Depends on rtp_pkg for the angle format and the arctangent table.
module rtp_step import rtp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ITERATIONS  = ITERATIONS_DEF,
  parameter int STEP        = 0,
  localparam int XW = COORD_WIDTH + 3,
  localparam int RB = COORD_WIDTH,
  localparam int SW = 2 * COORD_WIDTH,
  localparam int RW = RB + 2
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [XW-1:0]    x_in,
  input  logic signed [XW-1:0]    y_in,
  input  logic signed [ANG_W-1:0] z_in,
  input  logic        [SW-1:0]    sum_in,
  input  logic        [RW-1:0]    rem_in,
  input  logic        [RB-1:0]    root_in,
  input  logic                    origin_in,
  output logic signed [XW-1:0]    x_out,
  output logic signed [XW-1:0]    y_out,
  output logic signed [ANG_W-1:0] z_out,
  output logic        [SW-1:0]    sum_out,
  output logic        [RW-1:0]    rem_out,
  output logic        [RB-1:0]    root_out,
  output logic                    origin_out
);

  logic signed [XW-1:0]    x_next;
  logic signed [XW-1:0]    y_next;
  logic signed [ANG_W-1:0] z_next;
  logic        [RW-1:0]    rem_next;
  logic        [RB-1:0]    root_next;

  if (STEP < ITERATIONS) begin : g_rot
    localparam logic signed [ANG_W-1:0] ATAN = atan_q24(STEP);
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    // arithmetic shift is a floor shift
    assign xs = x_in >>> STEP;
    assign ys = y_in >>> STEP;

    always_comb begin
      if (!y_in[XW-1]) begin
        x_next = x_in + ys;
        y_next = y_in - xs;
        z_next = z_in + ATAN;
      end else begin
        x_next = x_in - ys;
        y_next = y_in + xs;
        z_next = z_in - ATAN;
      end
    end
  end else begin : g_rot_pass
    assign x_next = x_in;
    assign y_next = y_in;
    assign z_next = z_in;
  end

  if (STEP < RB) begin : g_root
    localparam int POS = 2 * (RB - 1 - STEP);
    logic [RW-1:0] acc;
    logic [RW-1:0] trial;

    // bring down the next two bits of the radicand, try root bit 1
    assign acc   = {rem_in[RW-3:0], sum_in[POS +: 2]};
    assign trial = {root_in, 2'b01};

    always_comb begin
      if (acc >= trial) begin
        rem_next  = acc - trial;
        root_next = {root_in[RB-2:0], 1'b1};
      end else begin
        rem_next  = acc;
        root_next = {root_in[RB-2:0], 1'b0};
      end
    end
  end else begin : g_root_pass
    assign rem_next  = rem_in;
    assign root_next = root_in;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_out      <= x_next;
      y_out      <= y_next;
      z_out      <= z_next;
      sum_out    <= sum_in;
      rem_out    <= rem_next;
      root_out   <= root_next;
      origin_out <= origin_in;
    end
  end

endmodule

// File: hw/rtl/rect_to_polar_converter.sv
// Pipelined rect-to-polar converter: integer rounded magnitude and Q13 atan2.
// Depends on rtp_pkg, rtp_point_if, rtp_polar_if, rtp_step and the macro header.
//
//   channel  dir  word
//   point    in   x_coord, y_coord   signed COORD_WIDTH bits each
//   polar    out  magnitude (16 u), angle_rad (16 s, pi = 25736)
//
// One word in per cycle, one word out per cycle, while polar is ready.
// The pipe stages in order are fold, square, sum,
// one stage per CORDIC rotation / root digit, then rounding and clamping.
// Reset clears the stage valid bits only.
// A stall at polar reaches back combinationally; empty stages keep filling,
// so point stays ready while any bubble remains in the pipe.
`include "rect_to_polar_converter_macros.svh"

module rect_to_polar_converter import rtp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ITERATIONS  = ITERATIONS_DEF
) (
  input logic         clk,
  input logic         rst,
  rtp_point_if.sink   point,
  rtp_polar_if.source polar
);

  localparam int XW    = COORD_WIDTH + 3;
  localparam int RB    = COORD_WIDTH;
  localparam int SW    = 2 * COORD_WIDTH;
  localparam int RW    = RB + 2;
  localparam int NSTEP = (ITERATIONS > RB) ? ITERATIONS : RB;
  localparam int LAST  = NSTEP + 3;
  localparam int MW    = RB + 1;
  localparam int EW    = (MW > OUT_W) ? MW : OUT_W;

  // ---------------- handshake ----------------
  logic [LAST:0] vld;
  logic [LAST:0] adv;
  logic [LAST:0] vld_in;

  assign adv[LAST] = !vld[LAST] || polar.ready;
  for (genvar k = 0; k < LAST; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end
  assign vld_in = {vld[LAST-1:0], point.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k <= LAST; k++) begin
        if (adv[k]) vld[k] <= vld_in[k];
      end
    end
  end

  assign point.ready = adv[0];
  assign polar.valid = vld[LAST];

  // ---------------- stage 0: fold into right half-plane ----------------
  logic signed [XW-1:0]          xe;
  logic signed [XW-1:0]          ye;
  logic signed [XW-1:0]          xn;
  logic signed [XW-1:0]          yn;
  logic                          left;
  logic        [COORD_WIDTH-1:0] ax0;
  logic        [COORD_WIDTH-1:0] ay0;
  logic signed [XW-1:0]          cx0;
  logic signed [XW-1:0]          cy0;
  logic signed [ANG_W-1:0]       cz0;
  logic                          org0;

  assign xe   = XW'(point.x_coord);
  assign ye   = XW'(point.y_coord);
  assign xn   = -xe;
  assign yn   = -ye;
  assign left = point.x_coord[COORD_WIDTH-1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ax0  <= left ? xn[COORD_WIDTH-1:0] : xe[COORD_WIDTH-1:0];
      ay0  <= point.y_coord[COORD_WIDTH-1] ? yn[COORD_WIDTH-1:0] : ye[COORD_WIDTH-1:0];
      cx0  <= left ? xn : xe;
      cy0  <= left ? yn : ye;
      if (!left) cz0 <= '0;
      else if (point.y_coord[COORD_WIDTH-1]) cz0 <= -PI_Q24;
      else cz0 <= PI_Q24;
      org0 <= (point.x_coord == '0) && (point.y_coord == '0);
    end
  end

  // ---------------- stage 1: squares ----------------
  logic        [SW-1:0]    sqx1;
  logic        [SW-1:0]    sqy1;
  logic signed [XW-1:0]    cx1;
  logic signed [XW-1:0]    cy1;
  logic signed [ANG_W-1:0] cz1;
  logic                    org1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sqx1 <= {{COORD_WIDTH{1'b0}}, ax0} * {{COORD_WIDTH{1'b0}}, ax0};
      sqy1 <= {{COORD_WIDTH{1'b0}}, ay0} * {{COORD_WIDTH{1'b0}}, ay0};
      cx1  <= cx0;
      cy1  <= cy0;
      cz1  <= cz0;
      org1 <= org0;
    end
  end

  // ---------------- stage 2: sum of squares ----------------
  logic signed [XW-1:0]    sx    [NSTEP+1];
  logic signed [XW-1:0]    sy    [NSTEP+1];
  logic signed [ANG_W-1:0] sz    [NSTEP+1];
  logic        [SW-1:0]    ssum  [NSTEP+1];
  logic        [RW-1:0]    srem  [NSTEP+1];
  logic        [RB-1:0]    sroot [NSTEP+1];
  logic                    sorg  [NSTEP+1];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ssum[0] <= sqx1 + sqy1;
      sx[0]   <= cx1;
      sy[0]   <= cy1;
      sz[0]   <= cz1;
      sorg[0] <= org1;
    end
  end

  assign srem[0]  = '0;
  assign sroot[0] = '0;

  // ---------------- rotation / root-digit stages ----------------
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    rtp_step #(
      .COORD_WIDTH (COORD_WIDTH),
      .ITERATIONS  (ITERATIONS),
      .STEP        (k)
    ) u_step (
      .clk        (clk),
      .load       (adv[k+3]),
      .x_in       (sx[k]),
      .y_in       (sy[k]),
      .z_in       (sz[k]),
      .sum_in     (ssum[k]),
      .rem_in     (srem[k]),
      .root_in    (sroot[k]),
      .origin_in  (sorg[k]),
      .x_out      (sx[k+1]),
      .y_out      (sy[k+1]),
      .z_out      (sz[k+1]),
      .sum_out    (ssum[k+1]),
      .rem_out    (srem[k+1]),
      .root_out   (sroot[k+1]),
      .origin_out (sorg[k+1])
    );
  end

  // ---------------- output stage: round and clamp ----------------
  logic        [MW-1:0]    mag_full;
  logic        [EW-1:0]    mag_ext;
  logic        [OUT_W-1:0] mag_next;
  logic signed [ANG_W-1:0] z_round;
  logic signed [ANG_W-1:0] z_q;
  logic signed [ANG_W-1:0] pi_ext;
  logic signed [OUT_W-1:0] ang_next;
  logic        [OUT_W-1:0] mag_q;
  logic signed [OUT_W-1:0] ang_q;

  // round up when the remainder passes the root: s > r*r + r
  assign mag_full = {1'b0, sroot[NSTEP]} + MW'(srem[NSTEP] > {2'b00, sroot[NSTEP]});
  assign mag_ext  = EW'(mag_full);
  assign mag_next = (mag_ext > EW'(MAG_MAX)) ? MAG_MAX : mag_ext[OUT_W-1:0];

  assign z_round = sz[NSTEP] + ROUND_BIAS;
  assign z_q     = z_round >>> ANG_SHIFT;
  assign pi_ext  = ANG_W'(OUT_PI);

  always_comb begin
    if (sorg[NSTEP]) ang_next = '0;
    else if (z_q > pi_ext) ang_next = OUT_PI;
    else if (z_q < -pi_ext) ang_next = -OUT_PI;
    else ang_next = z_q[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      mag_q <= mag_next;
      ang_q <= ang_next;
    end
  end

  assign polar.magnitude = mag_q;
  assign polar.angle_rad = ang_q;

  // ---------------- checks ----------------
  `RTP_ASSERT_IMPLY(a_origin_angle, clk, rst, polar.valid && (polar.magnitude == '0), polar.angle_rad == '0)
  `RTP_ASSERT_IMPLY(a_angle_range, clk, rst, polar.valid, (polar.angle_rad <= OUT_PI) && (polar.angle_rad >= -OUT_PI))
  `RTP_ASSERT_IMPLY(a_ready_flows, clk, rst, polar.ready, point.ready)
  `RTP_ASSERT_NEXT(a_empty_fill, clk, rst, point.valid && point.ready && (vld == '0), vld == (LAST+1)'(1))

endmodule

// File: test/polar_result_checker.sv
// Checker for the rect-to-polar converter: watches the point and polar channels,
// predicts each polar word from the accepted point and compares them in order.
// Depends on rtp_pkg, rtp_point_if and rtp_polar_if.
`timescale 1ns / 100ps

module polar_result_checker import rtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rtp_point_if        point,
  rtp_polar_if        polar,
  output int          fail_count,
  output int          pending,
  output int          points_seen,
  output int          results_seen
);

  localparam int MAX_REPORTS = 10;

  // atan(2^-i) with 24 fraction bits; past the table the step is an exact power of two
  localparam longint ATAN_Q24 [10] = '{
    13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768
  };

  typedef struct packed {
    logic        [OUT_W-1:0] mag;
    logic signed [OUT_W-1:0] ang;
  } polar_word_t;

  polar_word_t expected_polar [$];

  function automatic polar_word_t predict_polar(
    input logic signed [COORD_WIDTH_DEF-1:0] xin,
    input logic signed [COORD_WIDTH_DEF-1:0] yin
  );
    longint x, y, z, xs, ys, step, ang;
    longint unsigned rem, root, bitv;
    polar_word_t word;
    x = xin;
    y = yin;

    // digit-by-digit square root, then round up when the remainder passes the root
    rem = longint'(x * x + y * y);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (rem > root) root = root + 1;
    if (root > 64'hFFFF) root = 64'hFFFF;
    word.mag = root[OUT_W-1:0];

    if (x == 0 && y == 0) begin
      word.ang = '0;
      return word;
    end

    // fold the left half-plane over, starting the angle at +/- pi
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
      x = -x;
      y = -y;
    end

    for (int i = 0; i < ITERATIONS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (i < 10) step = ATAN_Q24[i];
      else if (i <= ANG_FRAC) step = longint'(1) << (ANG_FRAC - i);
      else step = 0;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end

    ang = (z + longint'(ROUND_BIAS)) >>> ANG_SHIFT;
    if (ang > longint'(OUT_PI)) ang = OUT_PI;
    if (ang < -longint'(OUT_PI)) ang = -longint'(OUT_PI);
    word.ang = ang[OUT_W-1:0];
    return word;
  endfunction

  always @(posedge clk) begin
    polar_word_t want;
    polar_word_t got;
    if (rst) begin
      expected_polar.delete();
      fail_count = 0;
      points_seen = 0;
      results_seen = 0;
    end else begin
      // retire the output word first: it can never belong to this edge's input
      if (polar.valid && polar.ready) begin
        got.mag = polar.magnitude;
        got.ang = polar.angle_rad;
        results_seen++;
        if (expected_polar.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%t: polar word with nothing outstanding: mag %0d angle %0d",
                     $realtime, got.mag, $signed(got.ang));
        end else begin
          want = expected_polar.pop_front();
          if (got.mag !== want.mag || got.ang !== want.ang) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%t: polar word %0d: expected mag %0d angle %0d, got mag %0d angle %0d",
                       $realtime, results_seen, want.mag, $signed(want.ang),
                       got.mag, $signed(got.ang));
          end
        end
      end
      if (point.valid && point.ready) begin
        expected_polar.push_back(predict_polar(point.x_coord, point.y_coord));
        points_seen++;
      end
    end
    pending = expected_polar.size();
  end

endmodule

// File: test/tb_rect_to_polar_converter.sv
// Top of the rect-to-polar converter testbench: clock, reset, point stimulus,
// output back-pressure, watchdog and verdict. Depends on rtp_pkg, both channel
// interfaces, the converter and polar_result_checker.
`timescale 1ns / 100ps

module tb_rect_to_polar_converter;
  import rtp_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_POINTS = 1230;
  localparam int PRESSURE_AT   = 400;
  localparam int PRESSURE_LEN  = 120;
  localparam int QUIET_POINTS  = 200;
  localparam int LONG_HOLD     = 240;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int NUM_CORNERS   = 24;

  typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;

  // origin, axes, extremes, left-half-plane signs and the +/- pi edge
  localparam coord_t CORNER_X [NUM_CORNERS] = '{
    16'sd0, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd32767, 16'sh8000, 16'sd0,
    16'sd0, 16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767, 16'sh8000, 16'sh8000, -16'sd1,
    16'sd1, -16'sd1, 16'sd1, -16'sd32767, 16'sd3, -16'sd21, 16'sd1, -16'sd1
  };
  localparam coord_t CORNER_Y [NUM_CORNERS] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd32767,
    16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000, -16'sd1, 16'sd1, -16'sd1,
    16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd4, 16'sd20, 16'sh8000, 16'sh8000
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_idle = 1'b0;
  logic sink_idle = 1'b0;
  logic long_hold_req = 1'b0;
  int   hold_left;
  int   stall_cycles;
  int   fail_count;
  int   pending;
  int   points_seen;
  int   results_seen;

  rtp_point_if point_ch ();
  rtp_polar_if polar_ch ();

  rect_to_polar_converter u_top (
    .clk   (clk),
    .rst   (rst),
    .point (point_ch),
    .polar (polar_ch)
  );

  polar_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .point        (point_ch),
    .polar        (polar_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .points_seen  (points_seen),
    .results_seen (results_seen)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Offer one point from a falling edge and return at the falling edge after
  // it is accepted, with valid still high.
  task automatic send_point(input coord_t x, input coord_t y);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      point_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    point_ch.x_coord = x;
    point_ch.y_coord = y;
    point_ch.valid = 1'b1;
    do @(posedge clk); while (!point_ch.ready);
    @(negedge clk);
  endtask

  task automatic random_point(output coord_t x, output coord_t y);
    int unsigned sel;
    coord_t far_end;
    sel = $urandom_range(0, 99);
    x = 16'($urandom);
    y = 16'($urandom);
    if (sel < 50) begin
      // full range as drawn
    end else if (sel < 65) begin
      x = 16'(int'($urandom_range(0, 16)) - 8);
      y = 16'(int'($urandom_range(0, 16)) - 8);
    end else if (sel < 85) begin
      // hug an axis
      if ($urandom_range(0, 1) == 0) x = 16'(int'($urandom_range(0, 6)) - 3);
      else y = 16'(int'($urandom_range(0, 6)) - 3);
    end else begin
      case ($urandom_range(0, 2))
        0:       far_end = 16'sh8000;
        1:       far_end = 16'sh8001;
        default: far_end = 16'sh7FFF;
      endcase
      if ($urandom_range(0, 1) == 0) x = far_end;
      else y = far_end;
    end
  endtask

  // Output side: random hold-off bursts, plus one long hold on request.
  initial begin
    polar_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        polar_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        polar_ch.ready = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        polar_ch.ready = 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 16);
        polar_ch.ready = 1'b0;
      end else begin
        polar_ch.ready = 1'b1;
      end
    end
  end

  // Count cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((point_ch.valid && point_ch.ready) || (polar_ch.valid && polar_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("** rect_to_polar_converter: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    coord_t x;
    coord_t y;
    point_ch.valid = 1'b0;
    point_ch.x_coord = '0;
    point_ch.y_coord = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle = 1'b1;
    sink_idle = 1'b1;
    for (int i = 0; i < NUM_CORNERS; i++) send_point(CORNER_X[i], CORNER_Y[i]);

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      // keep offering back to back while the output holds off, so the pipe fills
      if (n == PRESSURE_AT) begin
        src_idle = 1'b0;
        long_hold_req = 1'b1;
      end
      if (n == PRESSURE_AT + PRESSURE_LEN) src_idle = 1'b1;
      if (n == 700) sink_idle = 1'b0;
      if (n == 820) sink_idle = 1'b1;
      if (n == RANDOM_POINTS - QUIET_POINTS) begin
        src_idle = 1'b0;
        sink_idle = 1'b0;
      end
      random_point(x, y);
      send_point(x, y);
    end
    point_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d points (%0d origin, axis, extreme and pi-edge cases) and checked %0d polar words.",
             points_seen, NUM_CORNERS, results_seen);
    $display("Gaps on both channels, one long output hold-off, a gap-free tail; %0d failures.",
             fail_count);
    if (fail_count == 0) begin
      $display("** rect_to_polar_converter: PASSED **");
    end else begin
      $display("** rect_to_polar_converter: FAILED **");
    end
    $finish;
  end

endmodule
